>>> hw/rtl/upm_pkg.sv
// ----------------------------------------------------------------------------
// upm_pkg - shared types and tables of the underspeed pulse monitor
// Holds the sample and result word layouts, the hysteresis thresholds and the
// constant tables for the start-up delay and the underspeed timeout.
// ----------------------------------------------------------------------------
package upm_pkg;

	localparam int SampleW  = 8;
	localparam int CountW   = 10;
	localparam int RomDepth = 256;

	localparam logic [SampleW-1:0] PulseFallLevel = 8'h19;
	localparam logic [SampleW-1:0] PulseRiseLevel = 8'hE6;

	localparam int UpperHalf = 128;
	localparam int DelayBase = 100;
	localparam int SlowBase  = 1000;
	localparam int MidBase   = 100;
	localparam int FastEnd   = 10;
	localparam int Segments  = 9;

	localparam int MidStep  = (MidBase - FastEnd) / Segments;
	localparam int SlowStep = (SlowBase - MidBase) / Segments;

	// one setting step adds 256/72 ticks: a whole part and a remainder
	localparam int DelayScale = 256;
	localparam int DelayDiv   = 72;
	localparam int DelayStepQ = DelayScale / DelayDiv;
	localparam int DelayStepR = DelayScale % DelayDiv;

	localparam int Knots [10] = '{0, 6, 12, 20, 28, 39, 51, 67, 89, 128};

	typedef logic [CountW-1:0] rom_t [RomDepth];

	typedef struct packed {
		logic [SampleW-1:0] target_level;
		logic [SampleW-1:0] pulse_level;
	} sample_t;

	typedef struct packed {
		logic              relay_closed;
		logic              delay_active;
		logic              pulse_high;
		logic [CountW-1:0] elapsed_ticks;
		logic [CountW-1:0] timeout_ticks;
	} result_t;

	// Start-up delay per setting: 100 + setting*256/72 ticks (elaboration only)
	function automatic rom_t build_delay_rom();
		rom_t rom;
		int   quot;
		int   rem;
		quot = 0;
		rem  = 0;
		for (int s = 0; s < RomDepth; s++) begin
			rom[s] = CountW'(DelayBase + quot);
			// advance the running quotient by one setting step
			quot = quot + DelayStepQ;
			rem  = rem + DelayStepR;
			if (rem >= DelayDiv) begin
				rem  = rem - DelayDiv;
				quot = quot + 1;
			end
		end
		return rom;
	endfunction

	// Piecewise-linear timeout per target sample (elaboration only)
	function automatic rom_t build_timeout_rom();
		rom_t rom;
		int   v;
		int   base;
		int   step;
		int   seg;
		int   span;
		int   num;
		int   frac;
		for (int h = 0; h < RomDepth; h++) begin
			if (h >= UpperHalf) begin
				v    = h - UpperHalf;
				base = MidBase;
				step = MidStep;
			end else begin
				v    = h;
				base = SlowBase;
				step = SlowStep;
			end
			seg = 0;
			for (int k = 1; k < Segments; k++) begin
				if (Knots[k] <= v) begin
					seg = k;
				end
			end
			// scale the offset along the segment by its span
			span = Knots[seg + 1] - Knots[seg];
			num  = step * (v - Knots[seg]);
			frac = 0;
			while (num >= span) begin
				num  = num - span;
				frac = frac + 1;
			end
			rom[h] = CountW'(base - seg * step - frac);
		end
		return rom;
	endfunction

	localparam rom_t DelayRom   = build_delay_rom();
	localparam rom_t TimeoutRom = build_timeout_rom();

endpackage

>>> hw/rtl/upm_if.sv
// ----------------------------------------------------------------------------
// upm_if - valid/ready channels of the underspeed pulse monitor
// upm_sample_if carries one tick of samples, upm_result_if one status word.
// ----------------------------------------------------------------------------
interface upm_sample_if;
	logic                       valid;
	logic                       ready;
	logic [upm_pkg::SampleW-1:0] target_level;
	logic [upm_pkg::SampleW-1:0] pulse_level;

	modport source (output valid, output target_level, output pulse_level, input ready);
	modport sink   (input valid, input target_level, input pulse_level, output ready);
endinterface

interface upm_result_if;
	logic                      valid;
	logic                      ready;
	logic                      relay_closed;
	logic                      delay_active;
	logic                      pulse_high;
	logic [upm_pkg::CountW-1:0] elapsed_ticks;
	logic [upm_pkg::CountW-1:0] timeout_ticks;

	modport source (output valid, output relay_closed, output delay_active,
		output pulse_high, output elapsed_ticks, output timeout_ticks, input ready);
	modport sink   (input valid, input relay_closed, input delay_active,
		input pulse_high, input elapsed_ticks, input timeout_ticks, output ready);
endinterface

>>> hw/rtl/underspeed_pulse_monitor.sv
// ----------------------------------------------------------------------------
// underspeed_pulse_monitor - relay trip on missing speed pulses
// Each sample word is one tick with a target sample and a pulse level; each
// tick yields one status word on the result channel.
//
// Channels: sample (valid/ready, target_level and pulse_level), status
// (valid/ready, relay_closed, delay_active, pulse_high, elapsed_ticks,
// timeout_ticks). cfg_wr_en/cfg_wr_data write the start-up delay setting,
// which is read on the first tick after reset; write it while idle.
// Path: an accepted word passes the input register and then the result
// register before it is on status.
// Throughput: one word per cycle while status is not held off; the per-tick
// update is a table lookup, a 10-bit increment and a 10-bit compare between
// those two registers.
// Reset: arst_n clears the channels and the monitor: not started, pulse high,
// count zero, relay closed, setting zero.
// Stall: while status is held off, the result register keeps its word, the
// input register keeps one more, and sample.ready drops; no word is lost.
// ----------------------------------------------------------------------------
module underspeed_pulse_monitor (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [upm_pkg::SampleW-1:0] cfg_wr_data,
	upm_sample_if.sink                  sample,
	upm_result_if.source                status
);

	logic             valid_s1;
	upm_pkg::sample_t word_s1;
	logic             advance;
	logic             fire;
	upm_pkg::result_t result;

	assign fire = valid_s1 && advance;

	upm_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	upm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fire        (fire),
		.word_s1     (word_s1),
		.result      (result)
	);

	upm_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.result   (result),
		.advance  (advance),
		.status   (status)
	);

endmodule

>>> hw/rtl/upm_in_stage.sv
// ----------------------------------------------------------------------------
// upm_in_stage - input register
// Captures one sample word per cycle and holds it while the result side stalls.
// ----------------------------------------------------------------------------
module upm_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	upm_sample_if.sink        sample,
	input  logic              advance,
	output logic              valid_s1,
	output upm_pkg::sample_t  word_s1
);

	logic load;

	// take a new word whenever the stage is empty or drains this cycle
	assign load         = !valid_s1 || advance;
	assign sample.ready = load;

	// hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= sample.valid;
		end
	end

	// capture the payload
	always_ff @(posedge clk) begin
		if (load && sample.valid) begin
			word_s1.target_level <= sample.target_level;
			word_s1.pulse_level  <= sample.pulse_level;
		end
	end

endmodule

>>> hw/rtl/upm_core.sv
// ----------------------------------------------------------------------------
// upm_core - monitor state and per-tick update
// Runs the start-up delay, the pulse hysteresis, the elapsed counter and the
// trip latch, and forms the status word for the tick in stage one.
// ----------------------------------------------------------------------------
module upm_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [upm_pkg::SampleW-1:0] cfg_wr_data,
	input  logic                       fire,
	input  upm_pkg::sample_t           word_s1,
	output upm_pkg::result_t           result
);

	localparam logic [upm_pkg::CountW-1:0] CountMax = '1;

	logic [upm_pkg::SampleW-1:0] delay_setting_q;
	logic                        started_q, started_d;
	logic [upm_pkg::CountW-1:0]  delay_rem_q, delay_rem_d;
	logic [upm_pkg::CountW-1:0]  elapsed_q, elapsed_d;
	logic                        pulse_q, pulse_d;
	logic                        trip_q, trip_d;
	logic                        in_delay;
	logic [upm_pkg::CountW-1:0]  timeout;
	logic [upm_pkg::CountW-1:0]  timeout_out;

	// store the delay setting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_setting_q <= '0;
		end else if (cfg_wr_en) begin
			delay_setting_q <= cfg_wr_data;
		end
	end

	// advance the monitor by one tick
	always_comb begin
		started_d   = started_q;
		delay_rem_d = delay_rem_q;
		elapsed_d   = elapsed_q;
		pulse_d     = pulse_q;
		trip_d      = trip_q;
		in_delay    = 1'b0;
		timeout     = upm_pkg::TimeoutRom[word_s1.target_level];
		timeout_out = '0;
		if (trip_q) begin
			timeout_out = timeout;
		end else if (!started_q) begin
			// first tick loads the delay and counts as one of its ticks
			started_d   = 1'b1;
			delay_rem_d = upm_pkg::DelayRom[delay_setting_q] - 10'd1;
			in_delay    = 1'b1;
		end else if (delay_rem_q != '0) begin
			delay_rem_d = delay_rem_q - 10'd1;
			in_delay    = 1'b1;
		end else begin
			timeout_out = timeout;
			if (elapsed_q != CountMax) begin
				elapsed_d = elapsed_q + 10'd1;
			end
			if (pulse_q) begin
				pulse_d = word_s1.pulse_level > upm_pkg::PulseFallLevel;
				if (!pulse_d) begin
					elapsed_d = '0;
				end
			end else begin
				pulse_d = word_s1.pulse_level > upm_pkg::PulseRiseLevel;
			end
			trip_d = elapsed_d >= timeout;
		end
	end

	// update the state on each processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			delay_rem_q <= '0;
			elapsed_q   <= '0;
			pulse_q     <= 1'b1;
			trip_q      <= 1'b0;
		end else if (fire) begin
			started_q   <= started_d;
			delay_rem_q <= delay_rem_d;
			elapsed_q   <= elapsed_d;
			pulse_q     <= pulse_d;
			trip_q      <= trip_d;
		end
	end

	// form the status word
	always_comb begin
		result.relay_closed  = !trip_d;
		result.delay_active  = in_delay;
		result.pulse_high    = pulse_d;
		result.elapsed_ticks = elapsed_d;
		result.timeout_ticks = timeout_out;
	end

endmodule

>>> hw/rtl/upm_out_stage.sv
// ----------------------------------------------------------------------------
// upm_out_stage - result register
// Holds one status word until the receiver takes it.
// ----------------------------------------------------------------------------
module upm_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  upm_pkg::result_t result,
	output logic             advance,
	upm_result_if.source     status
);

	logic             valid_q;
	upm_pkg::result_t result_q;

	// drain stage one when the register is empty or being read
	assign advance = !valid_q || status.ready;

	// hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_s1;
		end
	end

	// capture the word
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= result;
		end
	end

	assign status.valid         = valid_q;
	assign status.relay_closed  = result_q.relay_closed;
	assign status.delay_active  = result_q.delay_active;
	assign status.pulse_high    = result_q.pulse_high;
	assign status.elapsed_ticks = result_q.elapsed_ticks;
	assign status.timeout_ticks = result_q.timeout_ticks;

endmodule

>>> hw/rtl/upm_checker.sv
// ----------------------------------------------------------------------------
// upm_checker - port-level checks of the underspeed pulse monitor
// Watches status words: trip latching, consistent fields, held while stalled.
// ----------------------------------------------------------------------------
module upm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       st_valid,
	input logic                       st_ready,
	input logic                       relay_closed,
	input logic                       delay_active,
	input logic [upm_pkg::CountW-1:0] elapsed_ticks,
	input logic [upm_pkg::CountW-1:0] timeout_ticks
);

	logic st_take;
	logic tripped_q;

	assign st_take = st_valid && st_ready;

	// remember a delivered trip
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tripped_q <= 1'b0;
		end else if (st_take && !relay_closed) begin
			tripped_q <= 1'b1;
		end
	end

	a_trip_latches: assert property (@(posedge clk) disable iff (!arst_n)
		st_take && tripped_q |-> !relay_closed)
		else $error("relay closed again after a trip");

	a_delay_no_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		st_take && delay_active |-> relay_closed && timeout_ticks == '0)
		else $error("timeout or trip during the start-up delay");

	a_count_below_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		st_take && relay_closed && !delay_active |-> elapsed_ticks < timeout_ticks)
		else $error("relay held with count at or past the timeout");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		st_valid && !st_ready |=> st_valid)
		else $error("status word withdrawn while stalled");

endmodule

bind underspeed_pulse_monitor upm_checker u_upm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.st_valid      (status.valid),
	.st_ready      (status.ready),
	.relay_closed  (status.relay_closed),
	.delay_active  (status.delay_active),
	.elapsed_ticks (status.elapsed_ticks),
	.timeout_ticks (status.timeout_ticks)
);

>>> test/upm_status_checker.sv
// ----------------------------------------------------------------------------
// upm_status_checker - status word checker for the underspeed pulse monitor
// Watches the sample and status channels and the setting writes. It keeps
// its own copy of the monitor state and predicts one status word per
// accepted sample word. Each status word is compared field by field with the
// oldest prediction. Mismatches and the number of words still due go to
// the top.
// ----------------------------------------------------------------------------
module upm_status_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [upm_pkg::SampleW-1:0] cfg_wr_data,
	upm_sample_if                       sample,
	upm_result_if                       status,
	output int                          mismatches,
	output int                          words_due
);
	import upm_pkg::*;

	localparam int Breakpoints [10] = '{0, 6, 12, 20, 28, 39, 51, 67, 89, 128};
	localparam logic [7:0] FallThreshold = 8'h19;
	localparam logic [7:0] RiseThreshold = 8'hE6;
	localparam logic [9:0] ElapsedMax    = 10'd1023;

	logic [7:0] delay_setting;
	logic       started_q;
	logic [9:0] delay_left;
	logic [9:0] elapsed;
	logic       pulse_hi;
	logic       tripped;
	result_t    status_due_q [$];

	// Map a target sample to its underspeed timeout in ticks
	function automatic logic [9:0] underspeed_limit(logic [7:0] target);
		int v;
		int base;
		int step;
		int seg;
		if (target[7]) begin
			v    = int'(target[6:0]);
			base = 100;
			step = 10;
		end else begin
			v    = int'(target);
			base = 1000;
			step = 100;
		end
		seg = 8;
		while (seg > 0 && v < Breakpoints[seg]) seg--;
		return 10'(base - seg * step
			- (step * (v - Breakpoints[seg])) / (Breakpoints[seg + 1] - Breakpoints[seg]));
	endfunction

	// Advance the monitor by one tick and return the status word it gives
	function automatic result_t advance_monitor(logic [7:0] target, logic [7:0] level);
		result_t    word;
		logic       in_delay;
		logic [9:0] limit;
		in_delay = 1'b0;
		limit    = '0;
		if (tripped) begin
			// frozen after the trip, only the timeout follows the sample
			limit = underspeed_limit(target);
		end else if (!started_q) begin
			started_q  = 1'b1;
			delay_left = 10'(100 + (int'(delay_setting) * 256) / 72 - 1);
			in_delay   = 1'b1;
		end else if (delay_left != '0) begin
			delay_left = delay_left - 10'd1;
			in_delay   = 1'b1;
		end else begin
			if (elapsed != ElapsedMax) elapsed = elapsed + 10'd1;
			limit = underspeed_limit(target);
			if (pulse_hi) begin
				pulse_hi = (level > FallThreshold);
				if (!pulse_hi) elapsed = '0;
			end else begin
				pulse_hi = (level > RiseThreshold);
			end
			if (elapsed >= limit) tripped = 1'b1;
		end
		word.relay_closed  = !tripped;
		word.delay_active  = in_delay;
		word.pulse_high    = pulse_hi;
		word.elapsed_ticks = elapsed;
		word.timeout_ticks = limit;
		return word;
	endfunction

	task automatic report(string what, logic [15:0] got, logic [15:0] want);
		mismatches++;
		if (mismatches <= 40) begin
			$display("upm_status_checker: %s got %0h expected %0h", what, got, want);
		end
	endtask

	// Track setting writes, predict on accepted samples, compare status words
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			delay_setting = '0;
			started_q     = 1'b0;
			delay_left    = '0;
			elapsed       = '0;
			pulse_hi      = 1'b1;
			tripped       = 1'b0;
			status_due_q.delete();
			words_due <= 0;
		end else begin
			if (cfg_wr_en) delay_setting = cfg_wr_data;
			if (sample.valid && sample.ready) begin
				status_due_q.push_back(advance_monitor(sample.target_level, sample.pulse_level));
			end
			if (status.valid && status.ready) begin
				if (status_due_q.size() == 0) begin
					report("status word with none due, elapsed", 16'(status.elapsed_ticks), 16'h0);
				end else begin
					want = status_due_q.pop_front();
					if (status.relay_closed !== want.relay_closed)
						report("relay_closed", 16'(status.relay_closed), 16'(want.relay_closed));
					if (status.delay_active !== want.delay_active)
						report("delay_active", 16'(status.delay_active), 16'(want.delay_active));
					if (status.pulse_high !== want.pulse_high)
						report("pulse_high", 16'(status.pulse_high), 16'(want.pulse_high));
					if (status.elapsed_ticks !== want.elapsed_ticks)
						report("elapsed_ticks", 16'(status.elapsed_ticks), 16'(want.elapsed_ticks));
					if (status.timeout_ticks !== want.timeout_ticks)
						report("timeout_ticks", 16'(status.timeout_ticks), 16'(want.timeout_ticks));
				end
			end
			words_due <= status_due_q.size();
		end
	end

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench top of the underspeed pulse monitor
// Drives the start-up delay, a directed walk over thresholds and table
// segments, random pulse trains that keep the relay closed, a forced trip
// and random words after the trip. Both sides idle at random. The checker
// beside the block predicts and compares each status word.
// ----------------------------------------------------------------------------
module tb;
	import upm_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int ItemGoal   = 1700;
	localparam int TripWords  = 30;
	localparam int FrozenWords = 100;

	// target in the upper byte, pulse level in the lower byte
	localparam logic [15:0] OpeningTicks [18] = '{
		16'h00FF, 16'h7F1A, 16'h8019, 16'hFFE6, 16'h86E7, 16'h0600,
		16'h0CFF, 16'h1480, 16'h1C00, 16'h2780, 16'h33FF, 16'h4320,
		16'h5910, 16'hA7E7, 16'hC31A, 16'hD905, 16'h0155, 16'hFEFF
	};

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;
	int         mismatches;
	int         words_due;
	int         send_idle_pct;
	int         recv_idle_pct;
	int         sent = 0;
	int         cycles = 0;

	upm_sample_if sample_ch ();
	upm_result_if status_ch ();

	underspeed_pulse_monitor dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.sample      (sample_ch),
		.status      (status_ch)
	);

	upm_status_checker status_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.sample      (sample_ch),
		.status      (status_ch),
		.mismatches  (mismatches),
		.words_due   (words_due)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// Hold off status words at random
	initial begin
		status_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			status_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic set_idling(int mode);
		case (mode)
			0: begin
				send_idle_pct = 10;
				recv_idle_pct = 63;
			end
			1: begin
				send_idle_pct = 63;
				recv_idle_pct = 10;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	// Offer one sample word and hold it until it is taken
	task automatic send_word(logic [7:0] target, logic [7:0] level);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid        <= 1'b1;
		sample_ch.target_level <= target;
		sample_ch.pulse_level  <= level;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		sent++;
	endtask

	// Drop valid and wait until every status word is back
	task automatic drain();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_setting(logic [7:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Slow trains keep to the lower half of targets, so the timeout stays
	// above any gap between falling edges; fast trains allow any target
	function automatic logic [7:0] pick_target(logic fast);
		return fast ? 8'($urandom) : 8'($urandom_range(0, 8'h7F));
	endfunction

	// One pulse period: falling word, low stretch with noise, rising word, high stretch
	task automatic pulse_burst();
		int         low_len;
		int         high_len;
		logic       fast;
		logic [7:0] level;
		fast     = ($urandom_range(0, 3) == 0);
		low_len  = fast ? $urandom_range(1, 5) : $urandom_range(1, 45);
		high_len = fast ? $urandom_range(1, 5) : $urandom_range(1, 45);
		send_word(pick_target(fast), 8'($urandom_range(0, 8'h19)));
		for (int k = 1; k < low_len; k++) begin
			if ($urandom_range(0, 9) == 0) level = 8'($urandom);
			else level = 8'($urandom_range(0, 8'hE6));
			send_word(pick_target(fast), level);
		end
		send_word(pick_target(fast), 8'($urandom_range(8'hE7, 8'hFF)));
		for (int k = 1; k < high_len; k++) begin
			send_word(pick_target(fast), 8'($urandom_range(8'h1A, 8'hFF)));
		end
	endtask

	initial begin
		logic [7:0] start_setting;
		int         startup_ticks;
		int         goal;
		int         train_words;
		arst_n                 = 1'b0;
		cfg_wr_en              = 1'b0;
		cfg_wr_data            = '0;
		sample_ch.valid        = 1'b0;
		sample_ch.target_level = '0;
		sample_ch.pulse_level  = '0;
		set_idling(0);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// setting before the first tick decides the start-up delay
		write_setting(8'hFF);
		write_setting(8'h00);
		case ($urandom_range(0, 2))
			0: start_setting = 8'h00;
			1: start_setting = 8'hFF;
			default: start_setting = 8'($urandom);
		endcase
		write_setting(start_setting);
		startup_ticks = 100 + (int'(start_setting) * 256) / 72;

		// split what the delay leaves of the word budget among the trains
		train_words = (ItemGoal - startup_ticks - $size(OpeningTicks) - TripWords
			- 3 * FrozenWords) / 3;
		if (train_words < 100) train_words = 100;

		// run through the start-up delay
		send_word(8'hFF, 8'h00);
		send_word(8'h00, 8'hFF);
		for (int k = 2; k < startup_ticks; k++) send_word(8'($urandom), 8'($urandom));

		// walk thresholds and table segments just after the delay
		foreach (OpeningTicks[k]) send_word(OpeningTicks[k][15:8], OpeningTicks[k][7:0]);

		// pulse trains that keep the relay closed
		for (int m = 0; m < 3; m++) begin
			set_idling(m);
			goal = sent + train_words;
			while (sent < goal) pulse_burst();
			drain();
		end

		// stop the pulses under a short timeout to force the trip
		for (int k = 0; k < TripWords; k++) begin
			send_word(8'($urandom_range(8'hC0, 8'hFF)), 8'($urandom_range(8'h1A, 8'hFF)));
		end
		drain();

		// frozen state after the trip; later writes must not matter
		for (int m = 0; m < 3; m++) begin
			case (m)
				0: write_setting(8'($urandom));
				1: write_setting(8'hFF);
				default: write_setting(8'h00);
			endcase
			set_idling(m);
			for (int k = 0; k < FrozenWords; k++) send_word(8'($urandom), 8'($urandom));
			drain();
		end

		if (mismatches == 0 && words_due == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
